// ===== rtl/sdnc_pkg.sv =====
// sdnc_pkg: shared constants, command/status structs and a population-count
// helper for the second-degree neighbour counter. No dependencies.
`default_nettype none

package sdnc_pkg;

	// default table size and field widths
	localparam int SDNC_MAX_PEOPLE = 64;
	localparam int NAME_W          = 64;
	localparam int IDX_W           = 6;
	localparam int CNT_W           = 6;
	localparam int LIMIT_W         = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

	// request opcodes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic name_scan;
		logic sel_b;
		logic cap_a;
		logic cap_b;
		logic alloc_a;
		logic alloc_b;
		logic adj_rd_a;
		logic adj_rd_b;
		logic adj_wr_a;
		logic adj_wr_b;
		logic rowp_ld;
		logic adj_scan;
		logic scan_clr;
		logic acc_mask;
		logic cnt_step;
		logic res_load;
		logic res_full;
	} sdnc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic op_query;
		logic name_done;
		logic hit;
		logic adj_end;
		logic found_a;
		logic found_b;
		logic full_add;
		logic full_query;
		logic cnt_done;
		logic out_free;
	} sdnc_sts_t;

	// population count of one byte
	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'd0, v[i]};
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sdnc_ram.sv =====
// sdnc_ram: generic simple dual-port RAM, one write and one read port,
// registered read data. No dependencies.
`default_nettype none

module sdnc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/sdnc_ctrl.sv =====
// sdnc_ctrl: sequencing state machine for add and query requests.
// Depends on sdnc_pkg (command and status structs, opcodes).
`default_nettype none

module sdnc_ctrl
	import sdnc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire sdnc_sts_t sts,
	output sdnc_cmd_t      cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SRCH_A  = 4'd1;
	localparam logic [3:0] S_SRCH_B  = 4'd2;
	localparam logic [3:0] S_CHECK   = 4'd3;
	localparam logic [3:0] S_ALLOC_A = 4'd4;
	localparam logic [3:0] S_ALLOC_B = 4'd5;
	localparam logic [3:0] S_RD_A    = 4'd6;
	localparam logic [3:0] S_WR_A    = 4'd7;
	localparam logic [3:0] S_RD_B    = 4'd8;
	localparam logic [3:0] S_WR_B    = 4'd9;
	localparam logic [3:0] S_Q_RD    = 4'd10;
	localparam logic [3:0] S_Q_LD    = 4'd11;
	localparam logic [3:0] S_Q_SCAN  = 4'd12;
	localparam logic [3:0] S_Q_MASK  = 4'd13;
	localparam logic [3:0] S_Q_CNT   = 4'd14;
	localparam logic [3:0] S_DONE    = 4'd15;

	logic [3:0] state_q, state_nxt;
	logic       full_q, full_nxt;

	assign in_stall = (state_q != S_IDLE);

	// next state and command decode
	always_comb begin
		state_nxt = state_q;
		full_nxt  = full_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					full_nxt    = 1'b0;
					state_nxt   = S_SRCH_A;
				end
			end
			S_SRCH_A: begin
				cmd.name_scan = 1'b1;
				if (sts.name_done) begin
					cmd.cap_a = 1'b1;
					if (!sts.op_query) begin
						state_nxt = S_SRCH_B;
					end else if (sts.hit) begin
						state_nxt = S_Q_RD;
					end else begin
						state_nxt = S_CHECK;
					end
				end
			end
			S_SRCH_B: begin
				cmd.name_scan = 1'b1;
				cmd.sel_b     = 1'b1;
				if (sts.name_done) begin
					cmd.cap_b = 1'b1;
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.op_query) begin
					if (sts.full_query) begin
						full_nxt  = 1'b1;
						state_nxt = S_DONE;
					end else begin
						state_nxt = S_ALLOC_A;
					end
				end else if (sts.full_add) begin
					full_nxt  = 1'b1;
					state_nxt = S_DONE;
				end else if (!sts.found_a) begin
					state_nxt = S_ALLOC_A;
				end else if (!sts.found_b) begin
					state_nxt = S_ALLOC_B;
				end else begin
					state_nxt = S_RD_A;
				end
			end
			S_ALLOC_A: begin
				cmd.alloc_a = 1'b1;
				if (sts.op_query) begin
					state_nxt = S_DONE;
				end else if (!sts.found_b) begin
					state_nxt = S_ALLOC_B;
				end else begin
					state_nxt = S_RD_A;
				end
			end
			S_ALLOC_B: begin
				cmd.alloc_b = 1'b1;
				state_nxt   = S_RD_A;
			end
			S_RD_A: begin
				cmd.adj_rd_a = 1'b1;
				state_nxt    = S_WR_A;
			end
			S_WR_A: begin
				cmd.adj_wr_a = 1'b1;
				state_nxt    = S_RD_B;
			end
			S_RD_B: begin
				cmd.adj_rd_b = 1'b1;
				state_nxt    = S_WR_B;
			end
			S_WR_B: begin
				cmd.adj_wr_b = 1'b1;
				state_nxt    = S_DONE;
			end
			S_Q_RD: begin
				cmd.adj_rd_a = 1'b1;
				state_nxt    = S_Q_LD;
			end
			S_Q_LD: begin
				cmd.rowp_ld = 1'b1;
				state_nxt   = S_Q_SCAN;
			end
			S_Q_SCAN: begin
				cmd.adj_scan = 1'b1;
				if (sts.adj_end) begin
					cmd.scan_clr = 1'b1;
					state_nxt    = S_Q_MASK;
				end
			end
			S_Q_MASK: begin
				cmd.acc_mask = 1'b1;
				state_nxt    = S_Q_CNT;
			end
			S_Q_CNT: begin
				if (sts.cnt_done) begin
					state_nxt = S_DONE;
				end else begin
					cmd.cnt_step = 1'b1;
				end
			end
			S_DONE: begin
				cmd.res_full = full_q;
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			full_q  <= full_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sdnc_dpath.sv =====
// sdnc_dpath: name table, adjacency matrix, scan counter, accumulator,
// population counter, limit register and output register.
// Depends on sdnc_pkg and sdnc_ram.
`default_nettype none

module sdnc_dpath
	import sdnc_pkg::*;
#(
	parameter int MAX_PEOPLE = SDNC_MAX_PEOPLE
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sdnc_cmd_t          cmd,
	output sdnc_sts_t               sts,
	input  wire logic               cfg_wr_en,
	input  wire logic [LIMIT_W-1:0] cfg_wr_data,
	input  wire logic               op,
	input  wire logic [NAME_W-1:0]  name_a_hi,
	input  wire logic [NAME_W-1:0]  name_a_lo,
	input  wire logic [NAME_W-1:0]  name_b_hi,
	input  wire logic [NAME_W-1:0]  name_b_lo,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [IDX_W-1:0]        index_a,
	output logic [IDX_W-1:0]        index_b,
	output logic [CNT_W-1:0]        second_degree_count,
	output logic                    table_full
);

	localparam int AW     = $clog2(MAX_PEOPLE);
	localparam int UW     = $clog2(MAX_PEOPLE + 1);
	localparam int CHUNKS = (MAX_PEOPLE + 7) / 8;
	localparam int ACC_W  = CHUNKS * 8;
	localparam int CHW    = $clog2(CHUNKS + 1);
	localparam int LW     = ((UW > LIMIT_W) ? UW : LIMIT_W) + 1;

	// request payload
	logic              op_q;
	logic [NAME_W-1:0] a_hi_q, a_lo_q, b_hi_q, b_lo_q;

	// indices and search results
	logic [AW-1:0] ia_q, ib_q;
	logic          found_a_q, found_b_q;

	// scan counter and read pipeline
	logic [UW-1:0] k_q;
	logic          v_s1;
	logic [AW-1:0] idx_s1;
	logic          avld_s1;

	// table occupancy, row valid bits, limit
	logic [UW-1:0]         used_q;
	logic [MAX_PEOPLE-1:0] adj_vld_q;
	logic [LIMIT_W-1:0]    node_limit_q;

	// query accumulator and counter
	logic [MAX_PEOPLE-1:0] rowp_q;
	logic [ACC_W-1:0]      acc_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CHW-1:0]        ch_q;

	// output register
	logic             out_valid_q;
	logic [IDX_W-1:0] index_a_q, index_b_q;
	logic [CNT_W-1:0] count_q;
	logic             full_q;

	// memory ports
	logic [NAME_W-1:0]     hi_rd, lo_rd, hi_wdata, lo_wdata;
	logic                  name_we, name_re;
	logic [MAX_PEOPLE-1:0] adj_rd, adj_wdata;
	logic                  adj_we, adj_re;
	logic [AW-1:0]         adj_raddr, adj_waddr, adj_other;

	logic          k_lt, same_ab, hit, or_en;
	logic [AW-1:0] k_addr;
	logic [NAME_W-1:0] cmp_hi, cmp_lo;
	logic [LW-1:0] lim, need;
	logic [CNT_W:0] cnt_sum;

	assign k_lt    = (k_q < used_q);
	assign k_addr  = k_q[AW-1:0];
	assign same_ab = (a_hi_q == b_hi_q) && (a_lo_q == b_lo_q);

	// name compare against the entry read last cycle
	assign cmp_hi = cmd.sel_b ? b_hi_q : a_hi_q;
	assign cmp_lo = cmd.sel_b ? b_lo_q : a_lo_q;
	assign hit    = v_s1 && (hi_rd == cmp_hi) && (lo_rd == cmp_lo);

	// name table write on allocation
	assign name_re  = cmd.name_scan && k_lt;
	assign name_we  = cmd.alloc_a || (cmd.alloc_b && !same_ab);
	assign hi_wdata = cmd.alloc_a ? a_hi_q : b_hi_q;
	assign lo_wdata = cmd.alloc_a ? a_lo_q : b_lo_q;

	sdnc_ram #(.WIDTH(NAME_W), .DEPTH(MAX_PEOPLE)) u_name_hi (
		.clk   (clk),
		.we    (name_we),
		.waddr (used_q[AW-1:0]),
		.wdata (hi_wdata),
		.re    (name_re),
		.raddr (k_addr),
		.rdata (hi_rd)
	);

	sdnc_ram #(.WIDTH(NAME_W), .DEPTH(MAX_PEOPLE)) u_name_lo (
		.clk   (clk),
		.we    (name_we),
		.waddr (used_q[AW-1:0]),
		.wdata (lo_wdata),
		.re    (name_re),
		.raddr (k_addr),
		.rdata (lo_rd)
	);

	// adjacency matrix: read-modify-write of one row, or row scan
	assign adj_re    = (cmd.adj_scan && k_lt) || cmd.adj_rd_a || cmd.adj_rd_b;
	assign adj_raddr = cmd.adj_scan ? k_addr : (cmd.adj_rd_b ? ib_q : ia_q);
	assign adj_we    = cmd.adj_wr_a || cmd.adj_wr_b;
	assign adj_waddr = cmd.adj_wr_b ? ib_q : ia_q;
	assign adj_other = cmd.adj_wr_b ? ia_q : ib_q;
	assign adj_wdata = (avld_s1 ? adj_rd : '0) | (MAX_PEOPLE'(1) << adj_other);

	sdnc_ram #(.WIDTH(MAX_PEOPLE), .DEPTH(MAX_PEOPLE)) u_adj (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.re    (adj_re),
		.raddr (adj_raddr),
		.rdata (adj_rd)
	);

	// room checks against the effective limit
	assign lim  = (LW'(node_limit_q) > LW'(MAX_PEOPLE)) ? LW'(MAX_PEOPLE)
	                                                    : LW'(node_limit_q);
	assign need = LW'(!found_a_q) + LW'(!found_b_q && !same_ab);

	// friend rows of the queried node feed the accumulator
	assign or_en   = cmd.adj_scan && v_s1 && avld_s1 && rowp_q[idx_s1] && (idx_s1 != ia_q);
	assign cnt_sum = (CNT_W + 1)'(cnt_q) + (CNT_W + 1)'(pop8(acc_q[7:0]));

	// status
	always_comb begin
		sts            = '0;
		sts.op_query   = (op_q == OP_QUERY);
		sts.hit        = hit;
		sts.name_done  = hit || (!v_s1 && !k_lt);
		sts.adj_end    = !v_s1 && !k_lt;
		sts.found_a    = found_a_q;
		sts.found_b    = found_b_q;
		sts.full_add   = (LW'(used_q) + need) > lim;
		sts.full_query = LW'(used_q) >= lim;
		sts.cnt_done   = (ch_q == '0);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q          <= '0;
			v_s1         <= 1'b0;
			used_q       <= '0;
			adj_vld_q    <= '0;
			node_limit_q <= LIMIT_RST;
			found_a_q    <= 1'b0;
			found_b_q    <= 1'b0;
			ch_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				node_limit_q <= cfg_wr_data;
			end
			// scan counter
			if (cmd.load_in || cmd.cap_a || cmd.cap_b || cmd.scan_clr) begin
				k_q  <= '0;
				v_s1 <= 1'b0;
			end else if (cmd.name_scan || cmd.adj_scan) begin
				v_s1 <= k_lt;
				if (k_lt) begin
					k_q <= k_q + UW'(1);
				end
			end
			if (cmd.cap_a) begin
				found_a_q <= hit;
			end
			if (cmd.cap_b) begin
				found_b_q <= hit;
			end
			// occupancy
			if (name_we) begin
				used_q <= used_q + UW'(1);
			end
			if (adj_we) begin
				adj_vld_q[adj_waddr] <= 1'b1;
			end
			// chunk counter for the population count
			if (cmd.acc_mask) begin
				ch_q <= CHW'(CHUNKS);
			end else if (cmd.cnt_step) begin
				ch_q <= ch_q - CHW'(1);
			end
			// output handshake
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= op;
			a_hi_q <= name_a_hi;
			a_lo_q <= name_a_lo;
			b_hi_q <= name_b_hi;
			b_lo_q <= name_b_lo;
			cnt_q  <= '0;
		end
		if (cmd.name_scan) begin
			idx_s1 <= k_addr;
		end else if (cmd.adj_scan) begin
			idx_s1 <= k_addr;
		end
		if (adj_re) begin
			avld_s1 <= adj_vld_q[adj_raddr];
		end
		// index capture and allocation
		if (cmd.cap_a) begin
			ia_q <= idx_s1;
		end else if (cmd.alloc_a) begin
			ia_q <= used_q[AW-1:0];
		end
		if (cmd.cap_b) begin
			ib_q <= idx_s1;
		end else if (cmd.alloc_b) begin
			ib_q <= same_ab ? ia_q : used_q[AW-1:0];
		end
		// accumulator: load, merge, mask, shift
		if (cmd.rowp_ld) begin
			rowp_q <= avld_s1 ? adj_rd : '0;
			acc_q  <= '0;
		end else if (or_en) begin
			acc_q <= acc_q | ACC_W'(adj_rd);
		end else if (cmd.acc_mask) begin
			acc_q <= acc_q & ~ACC_W'(rowp_q) & ~(ACC_W'(1) << ia_q);
		end else if (cmd.cnt_step) begin
			acc_q <= acc_q >> 8;
			cnt_q <= cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];
		end
		// result fields
		if (cmd.res_load) begin
			full_q    <= cmd.res_full;
			index_a_q <= cmd.res_full ? '0 : IDX_W'(ia_q);
			index_b_q <= (cmd.res_full || op_q == OP_QUERY) ? '0 : IDX_W'(ib_q);
			count_q   <= cmd.res_full ? '0 : cnt_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign index_a             = index_a_q;
	assign index_b             = index_b_q;
	assign second_degree_count = count_q;
	assign table_full          = full_q;

endmodule

`default_nettype wire

// ===== rtl/second_degree_neighbour_counter.sv =====
// second_degree_neighbour_counter: top level, controller plus datapath.
// Depends on sdnc_pkg, sdnc_ctrl, sdnc_dpath (and sdnc_ram below it).
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | op, name_a_hi/lo, name_b_hi/lo
//   out     | out_valid/out_stall  | index_a, index_b, second_degree_count,
//           |                      | table_full
//   cfg     | cfg_wr_en            | cfg_wr_data (node_limit)
//
// The work for a request grows with the number of names held: the
// linear name search and the adjacency row scan read one entry per cycle.
// Reset clears the table count and the per-row valid bits at once; no sweep.
// A request is taken while the previous result still waits in the output
// register; a stalled result holds the block only at its final step.
`default_nettype none

module second_degree_neighbour_counter
	import sdnc_pkg::*;
#(
	parameter int MAX_PEOPLE = SDNC_MAX_PEOPLE
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [LIMIT_W-1:0] cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               op,
	input  wire logic [NAME_W-1:0]  name_a_hi,
	input  wire logic [NAME_W-1:0]  name_a_lo,
	input  wire logic [NAME_W-1:0]  name_b_hi,
	input  wire logic [NAME_W-1:0]  name_b_lo,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [IDX_W-1:0]        index_a,
	output logic [IDX_W-1:0]        index_b,
	output logic [CNT_W-1:0]        second_degree_count,
	output logic                    table_full
);

	sdnc_cmd_t cmd;
	sdnc_sts_t sts;

	// sequencer
	sdnc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and arithmetic
	sdnc_dpath #(.MAX_PEOPLE(MAX_PEOPLE)) u_dpath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_wr_data         (cfg_wr_data),
		.op                  (op),
		.name_a_hi           (name_a_hi),
		.name_a_lo           (name_a_lo),
		.name_b_hi           (name_b_hi),
		.name_b_lo           (name_b_lo),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.index_a             (index_a),
		.index_b             (index_b),
		.second_degree_count (second_degree_count),
		.table_full          (table_full)
	);

endmodule

`default_nettype wire
